// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the radix text converter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ITRT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Expression must never be true outside reset.
`define ITRT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

// ----- sv/itrt_pkg.sv -----
// ----------------------------------------------------------------------------
// itrt_pkg
// Shared constants, types and the digit-to-character function.
// ----------------------------------------------------------------------------
`default_nettype none

package itrt_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int MAX_RADIX_DEFAULT  = 32;

    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 8;

    localparam logic [RADIX_W-1:0] MIN_RADIX = 6'd2;
    localparam logic [RADIX_W-1:0] DECIMAL   = 6'd10;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'd65;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

    typedef struct packed {
        logic load;
        logic div_step;
        logic store;
        logic emit_sign;
        logic emit_digit;
        logic emit_bad;
    } cmd_t;

    typedef struct packed {
        logic bad_radix;
        logic div_last;
        logic mag_zero;
        logic minus;
        logic last_digit;
        logic out_free;
    } stat_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d >= DIGIT_TEN)
        begin
            c = CHAR_UPPER + {2'b00, d - DIGIT_TEN};
        end
        else
        begin
            c = CHAR_ZERO + {2'b00, d};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- sv/integer_to_radix_text_unit.sv -----
// ----------------------------------------------------------------------------
// integer_to_radix_text_unit
// Converts a signed integer to ASCII text in radix 2..MAX_RADIX.
// ----------------------------------------------------------------------------
// Request channel: req_valid/req_stall with value and radix. A request is
// taken when req_valid is high and req_stall low; req_stall stays high from
// the accepting edge until the final character of that conversion has been
// loaded into the result register.
// Result channel: res_valid/res_stall with out_char, last and bad_radix, one
// character per transfer, most significant first, last on the final one. A
// '-' leads negative values in base 10 only. A bad radix gives one result
// with bad_radix set, out_char zero and last set.
// Each digit runs through the one-bit-per-cycle divider (one quotient bit per
// cycle) and then a store step; each character is then read from the digit
// RAM and loaded into the result register once it is free. One request is
// in flight at a time; the next is accepted while the final character still
// waits in the result register.
// A stalled receiver holds the result register and pauses emission.
// Reset clears all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_radix_text_unit #(
    parameter int VALUE_BITS = itrt_pkg::VALUE_BITS_DEFAULT,
    parameter int MAX_RADIX  = itrt_pkg::MAX_RADIX_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic signed [VALUE_BITS-1:0]  value,
    input  wire logic [itrt_pkg::RADIX_W-1:0]  radix,
    output logic                               res_valid,
    input  wire logic                          res_stall,
    output logic [itrt_pkg::CHAR_W-1:0]        out_char,
    output logic                               last,
    output logic                               bad_radix
);

    itrt_pkg::cmd_t  cmd;
    itrt_pkg::stat_t stat;

    itrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    itrt_dp #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_RADIX  (MAX_RADIX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .radix     (radix),
        .cmd       (cmd),
        .stat      (stat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .out_char  (out_char),
        .last      (last),
        .bad_radix (bad_radix)
    );

endmodule

`default_nettype wire

// ----- sv/itrt_ram.sv -----
// ----------------------------------------------------------------------------
// itrt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module itrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- sv/itrt_dp.sv -----
// ----------------------------------------------------------------------------
// itrt_dp
// Datapath: magnitude, bit-serial divider, digit store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module itrt_dp #(
    parameter int VALUE_BITS = itrt_pkg::VALUE_BITS_DEFAULT,
    parameter int MAX_RADIX  = itrt_pkg::MAX_RADIX_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic signed [VALUE_BITS-1:0]      value,
    input  wire logic [itrt_pkg::RADIX_W-1:0]      radix,
    input  wire itrt_pkg::cmd_t                    cmd,
    output itrt_pkg::stat_t                        stat,
    output logic                                   res_valid,
    input  wire logic                              res_stall,
    output logic [itrt_pkg::CHAR_W-1:0]            out_char,
    output logic                                   last,
    output logic                                   bad_radix
);

    localparam int BIT_W  = $clog2(VALUE_BITS);
    localparam int ADDR_W = $clog2(VALUE_BITS);
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(VALUE_BITS - 1);

    logic [VALUE_BITS-1:0]              mag_reg, mag_next;
    logic [itrt_pkg::DIGIT_W-1:0]       rem_reg, rem_next;
    logic [itrt_pkg::RADIX_W-1:0]       radix_reg, radix_next;
    logic                               minus_reg, minus_next;
    logic [BIT_W-1:0]                   bit_reg, bit_next;
    logic [CNT_W-1:0]                   cnt_reg, cnt_next;

    logic                               res_valid_reg, res_valid_next;
    logic [itrt_pkg::CHAR_W-1:0]        char_reg, char_next;
    logic                               last_reg, last_next;
    logic                               bad_reg, bad_next;

    logic [VALUE_BITS-1:0]              value_u, mag_in;
    logic [itrt_pkg::DIGIT_W:0]         trial, diff;
    logic                               q_bit;
    logic [itrt_pkg::DIGIT_W-1:0]       rd_data;
    logic [CNT_W-1:0]                   rd_idx;

    assign value_u = $unsigned(value);
    assign mag_in  = value_u[VALUE_BITS-1] ? (~value_u + VALUE_BITS'(1)) : value_u;

    assign trial = {rem_reg, mag_reg[VALUE_BITS-1]};
    assign diff  = trial - {1'b0, radix_reg};
    assign q_bit = (trial >= {1'b0, radix_reg});

    assign rd_idx = cnt_reg - CNT_W'(1);

    itrt_ram #(
        .WIDTH (itrt_pkg::DIGIT_W),
        .DEPTH (VALUE_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.store),
        .wr_addr (cnt_reg[ADDR_W-1:0]),
        .wr_data (rem_reg),
        .rd_addr (rd_idx[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        mag_next   = mag_reg;
        rem_next   = rem_reg;
        radix_next = radix_reg;
        minus_next = minus_reg;
        bit_next   = bit_reg;
        cnt_next   = cnt_reg;

        if (cmd.load)
        begin
            mag_next   = mag_in;
            rem_next   = '0;
            radix_next = radix;
            minus_next = value_u[VALUE_BITS-1] && (radix == itrt_pkg::DECIMAL);
            bit_next   = '0;
            cnt_next   = '0;
        end
        if (cmd.div_step)
        begin
            mag_next = {mag_reg[VALUE_BITS-2:0], q_bit};
            rem_next = q_bit ? diff[itrt_pkg::DIGIT_W-1:0] : trial[itrt_pkg::DIGIT_W-1:0];
            bit_next = (bit_reg == BIT_LAST) ? '0 : bit_reg + BIT_W'(1);
        end
        if (cmd.store)
        begin
            rem_next = '0;
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (cmd.emit_sign)
        begin
            minus_next = 1'b0;
        end
        if (cmd.emit_digit)
        begin
            cnt_next = rd_idx;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        bad_next       = bad_reg;

        if (cmd.emit_bad)
        begin
            res_valid_next = 1'b1;
            char_next      = itrt_pkg::CHAR_NONE;
            last_next      = 1'b1;
            bad_next       = 1'b1;
        end
        else if (cmd.emit_sign)
        begin
            res_valid_next = 1'b1;
            char_next      = itrt_pkg::CHAR_MINUS;
            last_next      = 1'b0;
            bad_next       = 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            res_valid_next = 1'b1;
            char_next      = itrt_pkg::digit_char(rd_data);
            last_next      = (cnt_reg == CNT_W'(1));
            bad_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg       <= '0;
            cnt_reg       <= '0;
            minus_reg     <= 1'b0;
            bit_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            mag_reg       <= mag_next;
            cnt_reg       <= cnt_next;
            minus_reg     <= minus_next;
            bit_reg       <= bit_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        bad_reg   <= bad_next;
    end

    always_comb
    begin
        stat.bad_radix  = (radix < itrt_pkg::MIN_RADIX) ||
                          (radix > itrt_pkg::RADIX_W'(MAX_RADIX));
        stat.div_last   = (bit_reg == BIT_LAST);
        stat.mag_zero   = (mag_reg == '0);
        stat.minus      = minus_reg;
        stat.last_digit = (cnt_reg == CNT_W'(1));
        stat.out_free   = !res_valid_reg || !res_stall;
    end

    assign res_valid = res_valid_reg;
    assign out_char  = char_reg;
    assign last      = last_reg;
    assign bad_radix = bad_reg;

    `ITRT_ASSERT(a_store_in_range, clk, rst_n, cmd.store |-> (cnt_reg < CNT_W'(VALUE_BITS)), "digit store overflow")
    `ITRT_ASSERT(a_rem_below_radix, clk, rst_n, cmd.div_step |-> (rem_reg < radix_reg), "partial remainder not below radix")
    `ITRT_NEVER(a_emit_empty, clk, rst_n, cmd.emit_digit && (cnt_reg == '0), "digit emitted with empty store")

endmodule

`default_nettype wire

// ----- sv/itrt_ctrl.sv -----
// ----------------------------------------------------------------------------
// itrt_ctrl
// Controller: sequences load, division steps, digit stores and emission.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module itrt_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire itrt_pkg::stat_t stat,
    output itrt_pkg::cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_STORE,
        S_SIGN,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_BAD
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.bad_radix ? S_BAD : S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.store = 1'b1;
                if (!stat.mag_zero)
                begin
                    state_next = S_DIV;
                end
                else if (stat.minus)
                begin
                    state_next = S_SIGN;
                end
                else
                begin
                    state_next = S_EMIT_RD;
                end
            end
            S_SIGN:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = S_EMIT_RD;
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    state_next     = stat.last_digit ? S_IDLE : S_EMIT_RD;
                end
            end
            S_BAD:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_bad = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ITRT_ASSERT(a_cmd_onehot, clk, rst_n, $onehot0(cmd), "more than one command at once")
    `ITRT_ASSERT(a_emit_needs_room, clk, rst_n, (cmd.emit_sign || cmd.emit_digit || cmd.emit_bad) |-> stat.out_free, "result overwritten while pending")
    `ITRT_ASSERT(a_last_ends, clk, rst_n, (cmd.emit_digit && stat.last_digit) |=> (state_reg == S_IDLE), "conversion did not end on last digit")

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the radix text converter. A directed table covers
// zero, the signed extremes, every sign rule and bad radixes. Random requests
// then run under several idle and stall mixes, a long output hold-off and a
// drain pause. Every character is checked against the expected text or a local predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int WATCHDOG_LIMIT = 12000;
    localparam int HOLD_CYCLES    = 2000;
    localparam int END_SETTLE     = 40;
    localparam int PHASE_ITEMS    = 100;
    localparam int PRESSURE_ITEMS = 6;
    localparam int DIR_ROWS       = 24;

    typedef enum logic [1:0] {CHK_MODEL, CHK_TEXT, CHK_BAD} row_check_t;

    typedef struct packed {
        logic [31:0] value;
        logic [5:0]  radix;
        row_check_t  check;
    } dir_row_t;

    typedef struct packed {
        logic [itrt_pkg::CHAR_W-1:0] ch;
        logic                        last;
        logic                        bad;
    } text_char_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            req_valid = 1'b0;
    logic                            req_stall;
    logic signed [31:0]              value     = '0;
    logic [itrt_pkg::RADIX_W-1:0]    radix     = '0;
    logic                            res_valid;
    logic                            res_stall = 1'b0;
    logic [itrt_pkg::CHAR_W-1:0]     out_char;
    logic                            last;
    logic                            bad_radix;

    text_char_t pending_chars[$];
    text_char_t next_char;
    int         fail_count     = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         hold_requests  = 0;
    int         hold_served    = 0;
    int         hold_left      = 0;
    int         idle_cycles    = 0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{32'd0,           6'd10, CHK_TEXT},
        '{32'd0,           6'd2,  CHK_TEXT},
        '{32'd1,           6'd2,  CHK_TEXT},
        '{32'hFFFF_FFFF,   6'd10, CHK_TEXT},
        '{32'hFFFF_FFFF,   6'd16, CHK_TEXT},
        '{32'hFFFF_FFFF,   6'd2,  CHK_TEXT},
        '{32'h7FFF_FFFF,   6'd10, CHK_TEXT},
        '{32'h8000_0000,   6'd10, CHK_TEXT},
        '{32'h8000_0000,   6'd2,  CHK_TEXT},
        '{32'h8000_0000,   6'd16, CHK_TEXT},
        '{32'h7FFF_FFFF,   6'd32, CHK_TEXT},
        '{32'd31,          6'd32, CHK_TEXT},
        '{32'd35,          6'd32, CHK_TEXT},
        '{-32'sd10,        6'd16, CHK_TEXT},
        '{-32'sd255,       6'd10, CHK_TEXT},
        '{32'd255,         6'd16, CHK_TEXT},
        '{32'd1000000000,  6'd10, CHK_TEXT},
        '{32'hFFFF_FFFF,   6'd0,  CHK_BAD},
        '{32'd5,           6'd1,  CHK_BAD},
        '{32'hFFFF_FFFF,   6'd33, CHK_BAD},
        '{32'd0,           6'd63, CHK_BAD},
        '{32'd12345,       6'd3,  CHK_MODEL},
        '{-32'sd987654,    6'd7,  CHK_MODEL},
        '{32'h5A5A_5A5A,   6'd31, CHK_MODEL}
    };

    // Magnitude only outside base 10, so minus one reads as 1
    string dir_text [DIR_ROWS] = '{
        "0",
        "0",
        "1",
        "-1",
        "1",
        "1",
        "2147483647",
        "-2147483648",
        "10000000000000000000000000000000",
        "80000000",
        "1VVVVVV",
        "V",
        "13",
        "A",
        "-255",
        "FF",
        "1000000000",
        "",
        "",
        "",
        "",
        "",
        "",
        ""
    };

    integer_to_radix_text_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .value     (value),
        .radix     (radix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .out_char  (out_char),
        .last      (last),
        .bad_radix (bad_radix)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Expected characters of one conversion, most significant first
    function automatic void predict_radix_text(input logic [31:0] v, input logic [5:0] r);
        logic [31:0]                  mag;
        logic [itrt_pkg::DIGIT_W-1:0] digit [32];
        logic [itrt_pkg::CHAR_W-1:0]  ch;
        int                           n;
        if (r < itrt_pkg::MIN_RADIX || int'(r) > itrt_pkg::MAX_RADIX_DEFAULT)
        begin
            pending_chars.push_back('{itrt_pkg::CHAR_NONE, 1'b1, 1'b1});
            return;
        end
        mag = v[31] ? -v : v;
        n = 0;
        while (mag != 0 && n < 32)
        begin
            digit[n] = itrt_pkg::DIGIT_W'(mag % {26'd0, r});
            mag = mag / {26'd0, r};
            n++;
        end
        if (n == 0)
        begin
            digit[0] = '0;
            n = 1;
        end
        if (v[31] && r == itrt_pkg::DECIMAL)
            pending_chars.push_back('{itrt_pkg::CHAR_MINUS, 1'b0, 1'b0});
        for (int k = n - 1; k >= 0; k--)
        begin
            if (digit[k] >= itrt_pkg::DIGIT_TEN)
                ch = itrt_pkg::CHAR_UPPER +
                     itrt_pkg::CHAR_W'(digit[k] - itrt_pkg::DIGIT_TEN);
            else
                ch = itrt_pkg::CHAR_ZERO + itrt_pkg::CHAR_W'(digit[k]);
            pending_chars.push_back('{ch, k == 0, 1'b0});
        end
    endfunction

    // Offers one request, returns at the edge that accepts it
    task automatic offer_request(input logic [31:0] v, input logic [5:0] r,
                                 input row_check_t check, input string text);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_valid <= 1'b1;
        value     <= v;
        radix     <= r;
        do
            @(posedge clk);
        while (req_stall);
        case (check)
            CHK_TEXT:
                for (int i = 0; i < text.len(); i++)
                    pending_chars.push_back('{itrt_pkg::CHAR_W'(text[i]),
                                              i == text.len() - 1, 1'b0});
            CHK_BAD:
                pending_chars.push_back('{itrt_pkg::CHAR_NONE, 1'b1, 1'b1});
            default:
                predict_radix_text(v, r);
        endcase
    endtask

    task automatic drain_results;
        req_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stall, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            res_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            res_stall   <= 1'b1;
        end
        else
        begin
            res_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected character out_char=%h last=%b bad_radix=%b",
                         $time, out_char, last, bad_radix);
                fail_count++;
            end
            else
            begin
                next_char = pending_chars.pop_front();
                if (out_char !== next_char.ch || last !== next_char.last ||
                    bad_radix !== next_char.bad)
                begin
                    $display("%0t: expected char/last/bad %h/%b/%b, got %h/%b/%b",
                             $time, next_char.ch, next_char.last, next_char.bad,
                             out_char, last, bad_radix);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, no transfer in %0d cycles", $time, WATCHDOG_LIMIT);
            $display("** integer_to_radix_text_unit: FAILED **");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [31:0] rnd_value;
        logic [5:0]  rnd_radix;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            offer_request(dir_rows[i].value, dir_rows[i].radix, dir_rows[i].check,
                          dir_text[i]);
        drain_results();

        // Output held off while requests keep coming
        hold_requests++;
        repeat (PRESSURE_ITEMS)
            offer_request($urandom, 6'($urandom_range(2, 32)), CHK_MODEL, "");
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            repeat (PHASE_ITEMS)
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3: rnd_value = $urandom;
                    4, 5:       rnd_value = $urandom_range(0, 999);
                    6:          rnd_value = -$urandom_range(1, 999);
                    7:
                        case ($urandom_range(4))
                            0: rnd_value = 32'd0;
                            1: rnd_value = 32'd1;
                            2: rnd_value = 32'hFFFF_FFFF;
                            3: rnd_value = 32'h7FFF_FFFF;
                            default: rnd_value = 32'h8000_0000;
                        endcase
                    8:       rnd_value = 32'd1 << $urandom_range(31);
                    default: rnd_value = $urandom >> $urandom_range(31);
                endcase
                if ($urandom_range(99) < 85)
                    rnd_radix = 6'($urandom_range(2, 32));
                else if ($urandom_range(1))
                    rnd_radix = 6'($urandom_range(0, 1));
                else
                    rnd_radix = 6'($urandom_range(33, 63));
                offer_request(rnd_value, rnd_radix, CHK_MODEL, "");
            end
            if (phase == 1)
                drain_results();
        end

        drain_results();
        repeat (END_SETTLE) @(posedge clk);
        if (pending_chars.size() != 0)
        begin
            $display("%0t: %0d expected characters never arrived", $time,
                     pending_chars.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("** integer_to_radix_text_unit: PASSED **");
        else
            $display("** integer_to_radix_text_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+sv
sv/itrt_pkg.sv
sv/itrt_ram.sv
sv/itrt_dp.sv
sv/itrt_ctrl.sv
sv/integer_to_radix_text_unit.sv
tb/sv/tb_top.sv
